// ----- rtl/core/button_debounce_hold_fsm_unit_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the button debounce / hold block
// Shared concurrent assertion wrappers, clocked on clk, reset rst_n.
// ---------------------------------------------------------------------------
`ifndef BUTTON_DEBOUNCE_HOLD_FSM_UNIT_MACROS_SVH
`define BUTTON_DEBOUNCE_HOLD_FSM_UNIT_MACROS_SVH

`ifndef ASSERT_OFF
// property checked outside reset
`define BDH_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("bdh assertion failed");
// property checked on every edge, reset included
`define BDH_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("bdh assertion failed");
`else
`define BDH_ASSERT(lbl, prop)
`define BDH_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

// ----- rtl/core/bdh_pkg.sv -----
// ---------------------------------------------------------------------------
// bdh_pkg
// Types, constants and helpers shared by the button debounce / hold block.
// ---------------------------------------------------------------------------
package bdh_pkg;

  localparam int NUM_BUTTONS = 4;
  localparam int TIME_W      = 32;
  localparam int CFG_W       = 16;
  localparam int STATUS_W    = 2;

  // configuration register indexes
  localparam logic REG_DEBOUNCE = 1'b0;
  localparam logic REG_HOLD     = 1'b1;

  // reported button status codes
  typedef logic [STATUS_W-1:0] status_t;
  localparam status_t STATUS_IDLE     = 2'd0;
  localparam status_t STATUS_PRESSED  = 2'd1;
  localparam status_t STATUS_HOLDING  = 2'd2;
  localparam status_t STATUS_RELEASED = 2'd3;

  typedef status_t [NUM_BUTTONS-1:0] status_vec_t;

  // per-button state machine, one-hot
  typedef enum logic [3:0] {
    MODE_IDLE     = 4'b0001,
    MODE_PRESSED  = 4'b0010,
    MODE_HOLDING  = 4'b0100,
    MODE_RELEASED = 4'b1000
  } mode_t;

  // common control fanned out to every lane
  typedef struct packed {
    logic              accept;
    logic [TIME_W-1:0] now_ms;
    logic [CFG_W-1:0]  debounce_ms;
    logic [CFG_W-1:0]  hold_ms;
  } lane_ctl_t;

  function automatic status_t mode_to_status(input mode_t mode);
    status_t code;
    unique case (mode)
      MODE_IDLE:     code = STATUS_IDLE;
      MODE_PRESSED:  code = STATUS_PRESSED;
      MODE_HOLDING:  code = STATUS_HOLDING;
      MODE_RELEASED: code = STATUS_RELEASED;
      default:       code = STATUS_IDLE;
    endcase
    return code;
  endfunction

endpackage

// ----- rtl/core/button_debounce_hold_fsm_unit.sv -----
// ---------------------------------------------------------------------------
// button_debounce_hold_fsm_unit
// Four-button debouncer with press / hold / release state machines.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall): one item is one sampling pass, a
//   millisecond timestamp plus the raw active-high level of each button.
//   Result channel (out_valid / out_stall): one item per input item, the
//   state of every button after that pass (0 idle, 1 pressed, 2 holding,
//   3 released).
//   Config port: cfg_we with cfg_index 0 writes the debounce time, index 1
//   the hold time (both ms, low 16 bits of cfg_wdata). Write while idle.
//   Output: each result is registered in the output register, or in the skid stage if the output is full and stalled.
//   Throughput: one item per cycle while in_stall is low; each button lane does its two 32-bit
//   subtract-compares and FSM step in the accepting cycle.
//   Stall: an output register and a one-deep skid stage hold up to two
//   results; in_stall rises only when both are full.
//   Reset: synchronous, active low. All buttons idle, last level pressed,
//   stamps zero, both times zero, output empty.
// ---------------------------------------------------------------------------
module button_debounce_hold_fsm_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  // input channel
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [bdh_pkg::TIME_W-1:0]  in_now_ms,
  input  logic                        in_pressed_0,
  input  logic                        in_pressed_1,
  input  logic                        in_pressed_2,
  input  logic                        in_pressed_3,
  // result channel
  output logic                        out_valid,
  input  logic                        out_stall,
  output bdh_pkg::status_t            out_status_0,
  output bdh_pkg::status_t            out_status_1,
  output bdh_pkg::status_t            out_status_2,
  output bdh_pkg::status_t            out_status_3,
  // configuration
  input  logic                        cfg_we,
  input  logic                        cfg_index,
  input  logic [bdh_pkg::CFG_W-1:0]   cfg_wdata
);

  logic [bdh_pkg::CFG_W-1:0]       debounce_r;
  logic [bdh_pkg::CFG_W-1:0]       hold_r;
  logic [bdh_pkg::NUM_BUTTONS-1:0] levels;
  bdh_pkg::lane_ctl_t              ctl;
  bdh_pkg::status_vec_t            lane_status;
  bdh_pkg::status_vec_t            merged;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_r <= '0;
      hold_r     <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bdh_pkg::REG_DEBOUNCE: debounce_r <= cfg_wdata;
        bdh_pkg::REG_HOLD:     hold_r     <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // shared lane control
  assign levels          = {in_pressed_3, in_pressed_2, in_pressed_1, in_pressed_0};
  assign ctl.accept      = in_valid && !in_stall;
  assign ctl.now_ms      = in_now_ms;
  assign ctl.debounce_ms = debounce_r;
  assign ctl.hold_ms     = hold_r;

  // one lane per button
  for (genvar b = 0; b < bdh_pkg::NUM_BUTTONS; b++) begin : g_lane
    bdh_lane u_lane (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctl        (ctl),
      .level      (levels[b]),
      .status_nxt (lane_status[b])
    );
  end

  // merge and output buffering
  bdh_merge u_merge (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .lane_status (lane_status),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_status  (merged)
  );

  assign out_status_0 = merged[0];
  assign out_status_1 = merged[1];
  assign out_status_2 = merged[2];
  assign out_status_3 = merged[3];

endmodule

// ----- rtl/core/bdh_lane.sv -----
// ---------------------------------------------------------------------------
// bdh_lane
// One button: raw level tracking, debounce timer and press/hold/release FSM.
// ---------------------------------------------------------------------------
`include "button_debounce_hold_fsm_unit_macros.svh"

module bdh_lane (
  input  logic                clk,
  input  logic                rst_n,
  input  bdh_pkg::lane_ctl_t  ctl,
  input  logic                level,
  output bdh_pkg::status_t    status_nxt
);

  logic                         last_r;
  logic [bdh_pkg::TIME_W-1:0]   chg_stamp_r;
  logic [bdh_pkg::TIME_W-1:0]   press_stamp_r;
  bdh_pkg::mode_t               mode_r;
  bdh_pkg::mode_t               mode_step;
  bdh_pkg::mode_t               mode_nxt;
  logic [bdh_pkg::TIME_W-1:0]   chg_elapsed;
  logic [bdh_pkg::TIME_W-1:0]   press_elapsed;
  logic                         level_diff;
  logic                         debounced;
  logic                         hold_over;
  logic                         run_fsm;
  logic                         new_press;

  // elapsed times, wrapping 32-bit
  assign level_diff    = (level != last_r);
  assign chg_elapsed   = ctl.now_ms - chg_stamp_r;
  assign press_elapsed = ctl.now_ms - press_stamp_r;
  assign debounced     = (chg_elapsed >= {{(bdh_pkg::TIME_W-bdh_pkg::CFG_W){1'b0}},
                                          ctl.debounce_ms});
  assign hold_over     = (press_elapsed > {{(bdh_pkg::TIME_W-bdh_pkg::CFG_W){1'b0}},
                                          ctl.hold_ms});
  assign run_fsm       = !level_diff && debounced;

  // FSM step on a stable, debounced level
  always_comb begin
    mode_step = mode_r;
    new_press = 1'b0;
    unique case (mode_r)
      bdh_pkg::MODE_IDLE: begin
        if (level) begin
          mode_step = bdh_pkg::MODE_PRESSED;
          new_press = 1'b1;
        end
      end
      bdh_pkg::MODE_PRESSED: begin
        if (!level) mode_step = bdh_pkg::MODE_RELEASED;
        else if (hold_over) mode_step = bdh_pkg::MODE_HOLDING;
      end
      bdh_pkg::MODE_HOLDING: begin
        if (!level) mode_step = bdh_pkg::MODE_RELEASED;
      end
      bdh_pkg::MODE_RELEASED: begin
        if (level) begin
          mode_step = bdh_pkg::MODE_PRESSED;
          new_press = 1'b1;
        end else begin
          mode_step = bdh_pkg::MODE_IDLE;
        end
      end
      default: mode_step = bdh_pkg::MODE_IDLE;
    endcase
  end

  assign mode_nxt   = run_fsm ? mode_step : mode_r;
  assign status_nxt = bdh_pkg::mode_to_status(mode_nxt);

  // state update on each accepted item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_r        <= 1'b1;
      chg_stamp_r   <= '0;
      press_stamp_r <= '0;
      mode_r        <= bdh_pkg::MODE_IDLE;
    end else if (ctl.accept) begin
      if (level_diff) begin
        last_r      <= level;
        chg_stamp_r <= ctl.now_ms;
      end
      if (run_fsm && new_press) press_stamp_r <= ctl.now_ms;
      mode_r <= mode_nxt;
    end
  end

  // a level change only records the change
  `BDH_ASSERT(a_chg_holds_mode,
    ctl.accept && level_diff |=> mode_r == $past(mode_r) && chg_stamp_r == $past(ctl.now_ms))
  // nothing moves without an item
  `BDH_ASSERT(a_idle_holds,
    !ctl.accept |=> $stable(mode_r) && $stable(last_r) && $stable(press_stamp_r))
  // a new press always stamps the press time
  `BDH_ASSERT(a_press_stamp,
    ctl.accept && run_fsm && new_press |=> mode_r == bdh_pkg::MODE_PRESSED
      && press_stamp_r == $past(ctl.now_ms))

endmodule

// ----- rtl/core/bdh_merge.sv -----
// ---------------------------------------------------------------------------
// bdh_merge
// Collects the lane results into one item; output register plus skid stage.
// ---------------------------------------------------------------------------
`include "button_debounce_hold_fsm_unit_macros.svh"

module bdh_merge (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  bdh_pkg::status_vec_t lane_status,
  output logic                 out_valid,
  input  logic                 out_stall,
  output bdh_pkg::status_vec_t out_status
);

  logic                 out_valid_r;
  logic                 skid_valid_r;
  bdh_pkg::status_vec_t out_data_r;
  bdh_pkg::status_vec_t skid_data_r;
  logic                 accept_in;
  logic                 take_out;

  assign in_stall   = skid_valid_r;
  assign accept_in  = in_valid && !skid_valid_r;
  assign take_out   = out_valid_r && !out_stall;
  assign out_valid  = out_valid_r;
  assign out_status = out_data_r;

  // control: output register refills from skid first, then from a new item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || take_out) begin
      out_valid_r  <= skid_valid_r || accept_in;
      skid_valid_r <= 1'b0;
    end else if (accept_in) begin
      skid_valid_r <= 1'b1;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (!out_valid_r || take_out) begin
      out_data_r <= skid_valid_r ? skid_data_r : lane_status;
    end else if (accept_in) begin
      skid_data_r <= lane_status;
    end
  end

  // skid only fills behind a full output register
  `BDH_ASSERT_ALWAYS(a_skid_behind_out, !rst_n || !skid_valid_r || out_valid_r)
  // an item taken while the output is stalled lands in the skid stage
  `BDH_ASSERT(a_skid_catch,
    accept_in && out_valid_r && out_stall |=> skid_valid_r)
  // a stalled result is never dropped
  `BDH_ASSERT(a_no_drop, out_valid_r && out_stall |=> out_valid_r)

endmodule
